// ----- rtl/swaabb_pkg.sv -----
`timescale 1ns / 1ps

package swaabb_pkg;

  // Field widths
  localparam int FW   = 32;  // signed Q16.16 coordinate
  localparam int HW   = 31;  // half size
  localparam int LW   = 8;   // layer byte
  localparam int SLW  = 6;   // slot index
  localparam int HTW  = 18;  // reported time, Q2.16
  localparam int BCW  = 7;   // box count register

  localparam int IN_TDATA_W  = 208;
  localparam int OUT_TDATA_W = 96;

  // Internal datapath widths
  localparam int GW   = 32;        // grown half size
  localparam int EW   = 34;        // slab edge
  localparam int NW   = 35;        // edge minus start point
  localparam int DW   = 52;        // dividend bits, even, covers NW + 16
  localparam int TW   = DW + 1;    // signed slab time
  localparam int MPW  = 54;        // multiplier bits, even, covers TW
  localparam int PW   = 33 + MPW;  // shift-add product register
  localparam int OFFW = 48;        // product after the Q16 shift
  localparam int SUMW = 49;        // start point plus offset
  localparam int CNTW = 5;

  localparam int DIV_STEPS = DW / 2;
  localparam int MUL_STEPS = MPW / 2;

  localparam logic signed [TW-1:0] ONE_Q16 = TW'(65536);
  localparam logic signed [TW-1:0] HT_MAX  = TW'(131071);
  localparam logic signed [TW-1:0] HT_MIN  = -TW'(131072);
  localparam logic [PW-1:0]        PROD_LIM = PW'(1) << 62;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic signed [FW-1:0] center_x;
    logic signed [FW-1:0] center_y;
    logic [HW-1:0]        half_x;
    logic [HW-1:0]        half_y;
    logic [LW-1:0]        layer;
  } box_t;

endpackage

// ----- rtl/swept_aabb_static_collision.sv -----
`timescale 1ns / 1ps

// Load transaction: written into the box RAM as it is accepted.
// Query: per table slot the box is read and rejected on its layer (layer rejected) or when outside on
// a still axis; else the slab times are divided out (slab miss or later than the kept hit ends the slot),
// and a candidate gets its contact point and normal, set by the 2-bit-per-cycle dividers and multipliers.
// One transaction at a time; a finished result waits in the output register.
// Reset clears the box count, control and the output valid; box RAM is undefined until loaded.
module swept_aabb_static_collision
  import swaabb_pkg::*;
#(
  parameter int MAX_BOXES   = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [BCW-1:0]         cfg_wdata_i,   // box_count
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // slot_index, center_x, center_y, half_x, half_y, vel_x, vel_y, layer_mask
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,  // req_type
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // hit_time, hit_pos_x, hit_pos_y, normal_x, normal_y, hit_index
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tuser   // hit_flag
);

  localparam int AW       = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int IW       = $clog2(MAX_BOXES + 1);
  localparam int POS_BITS = (COORD_WIDTH < FW) ? COORD_WIDTH : FW;
  localparam logic signed [SUMW-1:0] POS_MAX =
    SUMW'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
  localparam logic signed [SUMW-1:0] POS_MIN = -POS_MAX - SUMW'(1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_LOAD = 4'd2;
  localparam logic [3:0] S_EDGE = 4'd3;
  localparam logic [3:0] S_PREP = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_DFIN = 4'd6;
  localparam logic [3:0] S_SLAB = 4'd7;
  localparam logic [3:0] S_EVAL = 4'd8;
  localparam logic [3:0] S_MUL  = 4'd9;
  localparam logic [3:0] S_MFIN = 4'd10;
  localparam logic [3:0] S_MADD = 4'd11;
  localparam logic [3:0] S_NRM  = 4'd12;
  localparam logic [3:0] S_PEN  = 4'd13;
  localparam logic [3:0] S_NEXT = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  function automatic logic signed [SUMW-1:0] clamp_pos(input logic signed [SUMW-1:0] x);
    if (x > POS_MAX) return POS_MAX;
    if (x < POS_MIN) return POS_MIN;
    return x;
  endfunction

  // Input fields
  logic [SLW-1:0]       in_slot;
  logic signed [FW-1:0] in_cx, in_cy, in_vx, in_vy;
  logic [HW-1:0]        in_hx, in_hy;
  logic [LW-1:0]        in_mask;
  logic                 in_fire;

  assign in_slot = s_axis_tdata[5:0];
  assign in_cx   = s_axis_tdata[37:6];
  assign in_cy   = s_axis_tdata[69:38];
  assign in_hx   = s_axis_tdata[100:70];
  assign in_hy   = s_axis_tdata[131:101];
  assign in_vx   = s_axis_tdata[163:132];
  assign in_vy   = s_axis_tdata[195:164];
  assign in_mask = s_axis_tdata[203:196];

  logic [3:0] state_q, state_d;
  logic [BCW-1:0] box_count_q;
  logic [IW-1:0]  i_q, n_q;
  logic [CNTW-1:0] cnt_q;
  logic have_q, m_valid_q, out_free;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;

  // Box RAM
  box_t box_mem [MAX_BOXES];
  box_t rd_q;
  logic slot_ok;

  assign slot_ok = (32'(in_slot) < MAX_BOXES);

  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tuser == REQ_LOAD && slot_ok) begin
      box_mem[AW'(in_slot)] <= '{center_x: in_cx, center_y: in_cy, half_x: in_hx,
                                 half_y: in_hy, layer: in_mask};
    end
    rd_q <= box_mem[i_q[AW-1:0]];
  end

  // Query and per-box datapath
  logic signed [FW-1:0]   p_q [2];
  logic signed [FW-1:0]   v_q [2];
  logic signed [FW-1:0]   c_q [2];
  logic signed [FW-1:0]   pos_q [2];
  logic [HW-1:0]          hq_q [2];
  logic [GW-1:0]          h_q [2];
  logic [LW-1:0]          mask_q;
  logic signed [EW-1:0]   e_q [4];
  logic [DW-1:0]          dd_q [4];
  logic [31:0]            rem_q [4];
  logic                   nsign_q [4];
  logic signed [TW-1:0]   t_q [4];
  logic signed [TW-1:0]   entry_q, exit_q;
  logic                   entry_inf_q, exit_inf_q, moved_q;
  logic [PW-1:0]          pp_q [2];
  logic                   msign_q [2];
  logic signed [OFFW-1:0] off_q [2];
  logic signed [32:0]     d_q [2];
  logic [32:0]            ad_q [2];
  logic                   best_inf_q;
  logic signed [TW-1:0]   best_t_q;
  logic signed [FW-1:0]   best_pos_q [2];
  logic signed [1:0]      best_n_q [2];
  logic [SLW-1:0]         best_i_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                   out_flag_q;

  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_flag_q;

  logic [31:0] av [2];
  logic        vzero [2];
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      av[a]    = v_q[a][FW-1] ? 32'(-v_q[a]) : 32'(v_q[a]);
      vzero[a] = (v_q[a] == '0);
    end
  end

  // Slab setup
  logic signed [NW-1:0] num [4];
  logic [NW-1:0]        anum [4];
  logic                 slab_miss;
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      num[l]  = NW'(e_q[l]) - NW'(p_q[l >> 1]);
      anum[l] = num[l][NW-1] ? NW'(-num[l]) : NW'(num[l]);
    end
    slab_miss = 1'b0;
    for (int a = 0; a < 2; a++) begin
      if (vzero[a] && (p_q[a] <= e_q[2*a] || p_q[a] >= e_q[2*a+1])) slab_miss = 1'b1;
    end
  end

  // Four restoring dividers, two quotient bits per cycle
  logic [DW-1:0] div_dd_d [4];
  logic [31:0]   div_rem_d [4];
  always_comb begin
    logic [31:0]   r;
    logic [DW-1:0] d;
    logic [32:0]   rs;
    logic          qb;
    for (int l = 0; l < 4; l++) begin
      r = rem_q[l];
      d = dd_q[l];
      for (int k = 0; k < 2; k++) begin
        rs = {r, d[DW-1]};
        if (rs >= {1'b0, av[l >> 1]}) begin
          r  = 32'(rs - {1'b0, av[l >> 1]});
          qb = 1'b1;
        end else begin
          r  = rs[31:0];
          qb = 1'b0;
        end
        d = {d[DW-2:0], qb};
      end
      div_rem_d[l] = r;
      div_dd_d[l]  = d;
    end
  end

  // Two shift-add multipliers, two bits per cycle
  logic [PW-1:0] mul_d [2];
  always_comb begin
    logic [PW-1:0] pv;
    logic [32:0]   s;
    for (int a = 0; a < 2; a++) begin
      pv = pp_q[a];
      for (int k = 0; k < 2; k++) begin
        s  = pv[PW-1:MPW] + (pv[0] ? {1'b0, av[a]} : 33'd0);
        pv = {1'b0, s, pv[MPW-1:1]};
      end
      mul_d[a] = pv;
    end
  end

  // Slab combine
  logic signed [TW-1:0] tn [2];
  logic signed [TW-1:0] tx [2];
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      tn[a] = (t_q[2*a] < t_q[2*a+1]) ? t_q[2*a] : t_q[2*a+1];
      tx[a] = (t_q[2*a] < t_q[2*a+1]) ? t_q[2*a+1] : t_q[2*a];
    end
  end

  // Hit test and ordering against the kept hit
  logic hit, t_lt, t_eq, could_take;
  logic entry_neg;
  logic [TW-1:0] aent;
  assign hit = (exit_inf_q || entry_inf_q || exit_q > entry_q)
            && (exit_inf_q || exit_q > TW'(0))
            && (entry_inf_q || entry_q < ONE_Q16);
  assign t_lt = entry_inf_q ? !best_inf_q : (!best_inf_q && entry_q < best_t_q);
  assign t_eq = (entry_inf_q == best_inf_q) && (entry_inf_q || entry_q == best_t_q);
  assign could_take = !have_q || t_lt || t_eq;
  assign entry_neg  = entry_q[TW-1];
  assign aent       = entry_neg ? TW'(-entry_q) : TW'(entry_q);

  // Offset from the product
  logic [62:0]          msat [2];
  logic signed [63:0]   sv [2];
  logic signed [SUMW-1:0] psum [2];
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      msat[a] = (pp_q[a] > PROD_LIM) ? 63'(PROD_LIM) : pp_q[a][62:0];
      sv[a]   = msign_q[a] ? -$signed({1'b0, msat[a]}) : $signed({1'b0, msat[a]});
      psum[a] = clamp_pos(SUMW'(p_q[a]) + SUMW'(off_q[a]));
    end
  end

  // Normal and take decision
  logic signed [34:0] pen [2];
  logic               selx, take;
  logic signed [1:0]  nrm [2];
  logic signed [1:0]  dsg [2];
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      pen[a] = $signed({3'b000, h_q[a]}) - $signed({2'b00, ad_q[a]});
      dsg[a] = (d_q[a] > 0) ? 2'sb01 : ((d_q[a] < 0) ? 2'sb11 : 2'sb00);
    end
    selx   = (pen[0] < pen[1]);
    nrm[0] = selx ? dsg[0] : 2'sb00;
    nrm[1] = selx ? 2'sb00 : dsg[1];
    take   = !have_q || t_lt
          || (t_eq && ((av[0] > av[1] && nrm[0] != 2'sb00)
                    || (av[1] > av[0] && nrm[1] != 2'sb00)));
  end

  logic signed [TW-1:0] ht_sat;
  assign ht_sat = best_inf_q ? HT_MIN
                : (best_t_q > HT_MAX) ? HT_MAX
                : (best_t_q < HT_MIN) ? HT_MIN : best_t_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire && s_axis_tuser == REQ_QUERY) state_d = S_RD;
      S_RD:   state_d = (i_q == n_q) ? S_DONE : S_LOAD;
      S_LOAD: state_d = (|(mask_q & rd_q.layer)) ? S_EDGE : S_NEXT;
      S_EDGE: state_d = S_PREP;
      S_PREP: state_d = slab_miss ? S_NEXT : S_DIV;
      S_DIV:  if (cnt_q == CNTW'(DIV_STEPS - 1)) state_d = S_DFIN;
      S_DFIN: state_d = S_SLAB;
      S_SLAB: state_d = S_EVAL;
      S_EVAL: state_d = !(hit && could_take) ? S_NEXT : (moved_q ? S_MUL : S_NRM);
      S_MUL:  if (cnt_q == CNTW'(MUL_STEPS - 1)) state_d = S_MFIN;
      S_MFIN: state_d = S_MADD;
      S_MADD: state_d = S_NRM;
      S_NRM:  state_d = S_PEN;
      S_PEN:  state_d = S_NEXT;
      S_NEXT: state_d = S_RD;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      box_count_q <= '0;
      i_q         <= '0;
      cnt_q       <= '0;
      have_q      <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) box_count_q <= cfg_wdata_i;
      if (state_q == S_IDLE && in_fire) begin
        i_q    <= '0;
        have_q <= 1'b0;
      end
      if (state_q == S_NEXT) i_q <= i_q + IW'(1);
      if (state_q == S_PREP || state_q == S_EVAL) cnt_q <= '0;
      else if (state_q == S_DIV || state_q == S_MUL) cnt_q <= cnt_q + CNTW'(1);
      if (state_q == S_PEN && take) have_q <= 1'b1;
      if (state_q == S_DONE && out_free) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        p_q[0]  <= in_cx;
        p_q[1]  <= in_cy;
        hq_q[0] <= in_hx;
        hq_q[1] <= in_hy;
        v_q[0]  <= in_vx;
        v_q[1]  <= in_vy;
        mask_q  <= in_mask;
        n_q     <= (32'(box_count_q) > MAX_BOXES) ? IW'(MAX_BOXES) : IW'(box_count_q);
      end
      S_LOAD: begin
        c_q[0] <= rd_q.center_x;
        c_q[1] <= rd_q.center_y;
        h_q[0] <= {1'b0, rd_q.half_x} + {1'b0, hq_q[0]};
        h_q[1] <= {1'b0, rd_q.half_y} + {1'b0, hq_q[1]};
      end
      S_EDGE: begin
        for (int a = 0; a < 2; a++) begin
          e_q[2*a]   <= EW'(c_q[a]) - EW'(h_q[a]);
          e_q[2*a+1] <= EW'(c_q[a]) + EW'(h_q[a]);
        end
      end
      S_PREP: begin
        for (int l = 0; l < 4; l++) begin
          dd_q[l]    <= DW'({anum[l], 16'h0000});
          rem_q[l]   <= '0;
          nsign_q[l] <= num[l][NW-1];
        end
      end
      S_DIV: begin
        for (int l = 0; l < 4; l++) begin
          dd_q[l]  <= div_dd_d[l];
          rem_q[l] <= div_rem_d[l];
        end
      end
      S_DFIN: begin
        // floor the quotient when the signs differ
        for (int l = 0; l < 4; l++) begin
          if (nsign_q[l] ^ v_q[l >> 1][FW-1]) begin
            t_q[l] <= -$signed({1'b0, dd_q[l]}) - TW'(rem_q[l] != 32'd0);
          end else begin
            t_q[l] <= $signed({1'b0, dd_q[l]});
          end
        end
      end
      S_SLAB: begin
        entry_inf_q <= 1'b0;
        exit_inf_q  <= 1'b0;
        moved_q     <= 1'b1;
        if (!vzero[0] && !vzero[1]) begin
          entry_q <= (tn[0] > tn[1]) ? tn[0] : tn[1];
          exit_q  <= (tx[0] < tx[1]) ? tx[0] : tx[1];
        end else if (!vzero[0]) begin
          entry_q <= tn[0];
          exit_q  <= tx[0];
        end else if (!vzero[1]) begin
          entry_q <= tn[1];
          exit_q  <= tx[1];
        end else begin
          entry_q     <= '0;
          exit_q      <= '0;
          entry_inf_q <= 1'b1;
          exit_inf_q  <= 1'b1;
          moved_q     <= 1'b0;
        end
      end
      S_EVAL: begin
        for (int a = 0; a < 2; a++) begin
          pp_q[a]    <= PW'(aent);
          msign_q[a] <= v_q[a][FW-1] ^ entry_neg;
          // no motion at all: contact is the start point
          pos_q[a]   <= FW'(clamp_pos(SUMW'(p_q[a])));
        end
      end
      S_MUL: begin
        pp_q[0] <= mul_d[0];
        pp_q[1] <= mul_d[1];
      end
      S_MFIN: begin
        off_q[0] <= sv[0][63:16];
        off_q[1] <= sv[1][63:16];
      end
      S_MADD: begin
        pos_q[0] <= FW'(psum[0]);
        pos_q[1] <= FW'(psum[1]);
      end
      S_NRM: begin
        for (int a = 0; a < 2; a++) begin
          d_q[a]  <= 33'(pos_q[a]) - 33'(c_q[a]);
          ad_q[a] <= (pos_q[a] < c_q[a]) ? 33'(33'(c_q[a]) - 33'(pos_q[a]))
                                         : 33'(33'(pos_q[a]) - 33'(c_q[a]));
        end
      end
      S_PEN: begin
        if (take) begin
          best_inf_q    <= entry_inf_q;
          best_t_q      <= entry_q;
          best_pos_q[0] <= pos_q[0];
          best_pos_q[1] <= pos_q[1];
          best_n_q[0]   <= nrm[0];
          best_n_q[1]   <= nrm[1];
          best_i_q      <= SLW'(i_q);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_flag_q <= have_q;
          if (have_q) begin
            out_data_q <= {4'h0, best_i_q, best_n_q[1], best_n_q[0], best_pos_q[1],
                           best_pos_q[0], ht_sat[HTW-1:0]};
          end else begin
            out_data_q <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- bench/swept_aabb_static_collision_tb.sv -----
`timescale 1ns / 1ps

module swept_aabb_static_collision_tb
  import swaabb_pkg::*;
();

  localparam int  NBOX      = 64;
  localparam int  CYC_LIMIT = 4_000_000;
  localparam longint T_NEG_INF = 64'sh8000_0000_0000_0000;
  localparam longint T_POS_INF = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint PROD_CAP  = 64'sh4000_0000_0000_0000;

  typedef struct {
    bit               kind;
    bit [SLW-1:0]     slot;
    bit signed [31:0] cx, cy;
    bit [HW-1:0]      hx, hy;
    bit signed [31:0] vx, vy;
    bit [LW-1:0]      mask;
  } sweep_req_t;

  typedef struct {
    bit               flag;
    bit signed [17:0] t;
    bit signed [31:0] px, py;
    bit signed [1:0]  nx, ny;
    bit [SLW-1:0]     idx;
  } hit_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [BCW-1:0] cfg_wdata_i;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  swept_aabb_static_collision dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // Predictor state: box table and active box limit
  longint box_cx[NBOX], box_cy[NBOX], box_hx[NBOX], box_hy[NBOX];
  bit [7:0] box_layer[NBOX];
  int box_lim;

  sweep_req_t pend_q[$];
  hit_t       hit_q[$];
  int  errors;
  int  cycles;
  bit  took;
  int  tx_idle, rx_idle;
  int  rx_hold_cnt;
  bit  tx_pause;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint q16(longint v);
    return v * 65536;
  endfunction

  function automatic longint fdiv(longint a, longint b);
    longint r;
    r = a / b;
    if ((a % b != 0) && ((a < 0) != (b < 0))) r--;
    return r;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint mul_clip(longint v, longint t);
    longint av, at;
    bit neg;
    if (v == 0 || t == 0) return 0;
    neg = (v < 0) != (t < 0);
    av = v < 0 ? -v : v;
    at = t < 0 ? -t : t;
    if (at > PROD_CAP / av) return neg ? -PROD_CAP : PROD_CAP;
    return neg ? -(av * at) : av * at;
  endfunction

  // Narrow entry/exit by one axis; a still axis must sit strictly inside the slab.
  function automatic bit slab_axis(longint p, longint v, longint c, longint h,
                                   inout longint entry, inout longint ext);
    longint t1, t2, tn, tx;
    if (v == 0) return (p > c - h) && (p < c + h);
    t1 = fdiv((c - h - p) * 65536, v);
    t2 = fdiv((c + h - p) * 65536, v);
    tn = t1 < t2 ? t1 : t2;
    tx = t1 < t2 ? t2 : t1;
    if (tn > entry) entry = tn;
    if (tx < ext) ext = tx;
    return 1'b1;
  endfunction

  function automatic void contact_axis(longint p, longint v, longint entry, bit moved,
                                       longint c, longint h,
                                       output longint pos, output longint pen);
    longint d;
    if (moved) pos = clamp(p + fdiv(mul_clip(v, entry), 65536), -(64'sd1 <<< 31),
                           (64'sd1 <<< 31) - 1);
    else pos = p;
    d = pos - c;
    pen = h - (d < 0 ? -d : d);
  endfunction

  function automatic int sgn(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic bit sweep_box(longint px, longint py, longint vx, longint vy,
                                   longint cx, longint cy, longint hx, longint hy,
                                   output longint t, output longint ox, output longint oy,
                                   output int nx, output int ny);
    longint entry, ext, penx, peny;
    bit moved;
    entry = T_NEG_INF;
    ext = T_POS_INF;
    nx = 0;
    ny = 0;
    t = 0;
    ox = 0;
    oy = 0;
    if (!slab_axis(px, vx, cx, hx, entry, ext)) return 1'b0;
    if (!slab_axis(py, vy, cy, hy, entry, ext)) return 1'b0;
    if (!(ext > entry && ext > 0 && entry < 65536)) return 1'b0;
    moved = (vx != 0) || (vy != 0);
    contact_axis(px, vx, entry, moved, cx, hx, ox, penx);
    contact_axis(py, vy, entry, moved, cy, hy, oy, peny);
    if (penx < peny) nx = sgn(ox - cx);
    else ny = sgn(oy - cy);
    t = entry;
    return 1'b1;
  endfunction

  function automatic hit_t sweep_table(sweep_req_t r);
    hit_t   best;
    bit     have, take;
    longint px, py, vx, vy, avx, avy, t, ox, oy, best_t;
    int     nx, ny;
    best = '{default: 0};
    have = 1'b0;
    best_t = 0;
    px = r.cx;
    py = r.cy;
    vx = r.vx;
    vy = r.vy;
    avx = vx < 0 ? -vx : vx;
    avy = vy < 0 ? -vy : vy;
    for (int i = 0; i < box_lim; i++) begin
      if ((r.mask & box_layer[i]) == 0) continue;
      if (!sweep_box(px, py, vx, vy, box_cx[i], box_cy[i], box_hx[i] + r.hx,
                     box_hy[i] + r.hy, t, ox, oy, nx, ny)) continue;
      if (!have || t < best_t) take = 1'b1;
      else if (t == best_t) take = (avx > avy && nx != 0) || (avy > avx && ny != 0);
      else take = 1'b0;
      if (take) begin
        have = 1'b1;
        best_t = t;
        best.flag = 1'b1;
        best.t = 18'(clamp(t, -131072, 131071));
        best.px = 32'(ox);
        best.py = 32'(oy);
        best.nx = 2'(nx);
        best.ny = 2'(ny);
        best.idx = 6'(i);
      end
    end
    return best;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Input side: predict on every accepted transaction
  always @(posedge clk_i) begin
    sweep_req_t r;
    if (rst_ni && cfg_we_i) box_lim = cfg_wdata_i > NBOX ? NBOX : cfg_wdata_i;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      r = pend_q.pop_front();
      took = 1'b1;
      if (r.kind == REQ_LOAD) begin
        box_cx[r.slot] = r.cx;
        box_cy[r.slot] = r.cy;
        box_hx[r.slot] = r.hx;
        box_hy[r.slot] = r.hy;
        box_layer[r.slot] = r.mask;
      end else begin
        hit_q.push_back(sweep_table(r));
      end
    end
  end

  // Output side
  always @(posedge clk_i) begin
    hit_t w, g;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      g.flag = m_axis_tuser;
      g.t = m_axis_tdata[17:0];
      g.px = m_axis_tdata[49:18];
      g.py = m_axis_tdata[81:50];
      g.nx = m_axis_tdata[83:82];
      g.ny = m_axis_tdata[85:84];
      g.idx = m_axis_tdata[91:86];
      if (hit_q.size() == 0) begin
        report("unexpected result, hit_flag", g.flag, 0);
      end else begin
        w = hit_q.pop_front();
        if (g.flag != w.flag) report("hit_flag", g.flag, w.flag);
        if (g.t != w.t) report("hit_time", g.t, w.t);
        if (g.px != w.px) report("hit_pos_x", g.px, w.px);
        if (g.py != w.py) report("hit_pos_y", g.py, w.py);
        if (g.nx != w.nx) report("normal_x", g.nx, w.nx);
        if (g.ny != w.ny) report("normal_y", g.ny, w.ny);
        if (g.idx != w.idx) report("hit_index", g.idx, w.idx);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (rx_hold_cnt > 0) rx_hold_cnt--;
    if (cycles > CYC_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Driver: hold the offered transaction until it is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || took)) begin
      took = 1'b0;
      if (pend_q.size() != 0 && !tx_pause && $urandom_range(99) >= tx_idle) begin
        s_axis_tuser <= pend_q[0].kind;
        s_axis_tdata <= {4'b0, pend_q[0].mask, pend_q[0].vy, pend_q[0].vx, pend_q[0].hy,
                         pend_q[0].hx, pend_q[0].cy, pend_q[0].cx, pend_q[0].slot};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= rst_ni && rx_hold_cnt == 0 && $urandom_range(99) >= rx_idle;
  end

  function automatic longint spread(longint r);
    return longint'($urandom_range(32'(2 * r))) - r;
  endfunction

  task automatic push_load(int slot, longint cx, longint cy, longint hx, longint hy,
                           bit [7:0] layer);
    sweep_req_t r;
    r = '{REQ_LOAD, 6'(slot), 32'(cx), 32'(cy), 31'(hx), 31'(hy), 32'sd0, 32'sd0, layer};
    pend_q.push_back(r);
  endtask

  task automatic push_query(longint cx, longint cy, longint hx, longint hy,
                            longint vx, longint vy, bit [7:0] mask);
    sweep_req_t r;
    r = '{REQ_QUERY, 6'($urandom), 32'(cx), 32'(cy), 31'(hx), 31'(hy), 32'(vx), 32'(vy),
          mask};
    pend_q.push_back(r);
  endtask

  task automatic load_small(int slot);
    push_load(slot, spread(q16(200)), spread(q16(200)), $urandom_range(q16(30)),
              $urandom_range(q16(30)), 8'($urandom_range(1, 255)));
  endtask

  task automatic push_random();
    int     k, s, sel;
    longint sx, sy, vx, vy, tx, ty;
    sweep_req_t r;
    sel = $urandom_range(99);
    if (sel < 4) begin
      r = '{REQ_LOAD, 6'($urandom), 32'($urandom), 32'($urandom), 31'($urandom),
            31'($urandom), 32'($urandom), 32'($urandom), 8'($urandom)};
      pend_q.push_back(r);
    end else if (sel < 12) begin
      load_small($urandom_range(63));
    end else if (sel < 24) begin
      r = '{REQ_QUERY, 6'($urandom), 32'($urandom), 32'($urandom), 31'($urandom),
            31'($urandom), 32'($urandom), 32'($urandom), 8'($urandom)};
      pend_q.push_back(r);
    end else if (sel < 34) begin
      push_query(spread(q16(300)), spread(q16(300)), $urandom_range(q16(10)),
                 $urandom_range(q16(10)), spread(q16(300)), spread(q16(300)),
                 8'($urandom));
    end else begin
      // aim at a box within the active limit, or at any slot when the limit is zero
      s = box_lim > 0 ? $urandom_range(box_lim - 1) : $urandom_range(63);
      tx = box_cx[s];
      ty = box_cy[s];
      sx = tx + spread(q16(150));
      sy = ty + spread(q16(150));
      k = $urandom_range(1, 8);
      vx = (tx - sx) * k / 4;
      vy = (ty - sy) * k / 4;
      case ($urandom_range(5))
        0: begin
          vx = 0;
          sx = tx + spread(q16(5));
        end
        1: begin
          vy = 0;
          sy = ty + spread(q16(5));
        end
        2: begin
          vx = 0;
          vy = 0;
          sx = tx + spread(q16(5));
          sy = ty + spread(q16(5));
        end
        default: ;
      endcase
      push_query(sx, sy, $urandom_range(q16(8)), $urandom_range(q16(8)), vx, vy,
                 $urandom_range(3) == 0 ? 8'($urandom) : box_layer[s] | 8'($urandom));
    end
  endtask

  task automatic drain();
    while (pend_q.size() != 0 || hit_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_count(int v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 7'(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) push_random();
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    took = 1'b0;
    tx_pause = 1'b0;
    rx_hold_cnt = 0;
    tx_idle = 19;
    rx_idle = 67;
    box_lim = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_count(0);
    for (int i = 0; i < NBOX; i++) load_small(i);
    push_load(10, q16(1000), 0, q16(10), q16(10), 8'h01);
    push_load(11, q16(1000), 0, q16(10), q16(10), 8'h03);
    push_load(12, -q16(1000), q16(500), q16(5), q16(5), 8'h80);
    push_load(63, 64'sh8000_0000 - 64'sh1_0000_0000, 64'sh7FFF_FFFF, 31'h7FFF_FFFF,
              31'h7FFF_FFFF, 8'hFF);
    // empty table walk
    push_query(q16(1), q16(1), q16(1), q16(1), q16(1), q16(1), 8'hFF);
    drain();
    set_count(64);
    push_query(-64'sh8000_0000, 64'sh7FFF_FFFF, 31'h7FFF_FFFF, 0, 64'sh7FFF_FFFF,
               -64'sh8000_0000, 8'hFF);
    push_load(63, 0, q16(150), q16(3), q16(3), 8'h40);
    push_query(q16(900), 0, q16(2), q16(2), q16(200), 0, 8'h01);        // equal times
    push_query(-q16(1000), q16(600), q16(2), q16(2), 0, -q16(200), 8'h80);
    push_query(-q16(1000), q16(500), q16(2), q16(2), 0, 0, 8'h80);      // still, inside
    push_query(q16(5000), q16(5000), q16(2), q16(2), 0, 0, 8'hFF);      // still, outside
    push_query(q16(900), 0, q16(2), q16(2), q16(200), 0, 8'h00);        // masked out
    push_query(q16(1000), 0, q16(2), q16(2), q16(50), 0, 8'h02);        // starts inside
    push_query(q16(900), q16(50), q16(2), q16(2), q16(200), 0, 8'h01);  // off the slab
    push_query(-q16(1100), q16(400), q16(2), q16(2), q16(100), q16(100), 8'h80);
    push_query(q16(1100), q16(8), q16(2), q16(2), -q16(200), -1, 8'h03);
    push_query(q16(700), 0, 0, 0, 1, 0, 8'h01);                         // tiny step
    drain();

    set_count(8);
    rx_hold_cnt = 3000;
    run_random(20);
    drain();

    tx_idle = 67;
    rx_idle = 19;
    set_count(127);
    run_random(15);
    drain();

    tx_idle = 0;
    rx_idle = 0;
    set_count(3);
    run_random(10);
    repeat (300) @(posedge clk_i);
    // hold the sender until every expected result is out
    tx_pause = 1'b1;
    while (hit_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    tx_pause = 1'b0;
    drain();
    tx_pause = 1'b1;
    run_random(10);
    repeat (200) @(posedge clk_i);
    tx_pause = 1'b0;
    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
